// ===== rtl/core/lbp_pkg.sv =====
`timescale 1ns / 1ps
package lbp_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int ADDR_BITS_DEF = 32;

  localparam int PAGE_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 4;
  localparam int PIN_W   = 16;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  localparam logic OP_PIN     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_HIT        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FREE       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EVICT      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ALL_PINNED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RELEASED   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_REL_MISS   = 3'd5;

  typedef struct packed {
    logic              opcode;
    logic [PAGE_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] frame_index;
    logic              needs_writeback;
    logic [PAGE_W-1:0] victim_addr;
  } rsp_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_UPD
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic latch_dec;
    logic commit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/core/lru_buffer_pool_frame_manager.sv =====
`timescale 1ns / 1ps
// A request is registered, its lookup result is registered in the lookup state, and
//   the result is registered on commit, which waits while the output holds a stalled
//   result. The next request is taken on the commit edge, not during the lookup.
// Reset (synchronous, rst_n low): clears frame valid bits, pin counts, output valid
//   and the controller; tags and recency ages are written before they are read.
module lru_buffer_pool_frame_manager import lbp_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer: idle -> lookup -> commit. Commit waits while the output
  // register holds a result that is stalled.
  lbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame table: parallel tag match, first free frame, and LRU search
  // over unpinned frames by age bucket. Ages give the recency order:
  // a hit or eviction moves the frame to age zero, a fill ages everyone.
  lbp_datapath #(
    .FRAMES    (FRAMES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // Assertions

  // after a request is taken the block is busy with the lookup
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted during lookup");

  // writeback flag only with eviction
  a_wb_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.needs_writeback == (out_rsp.status == STAT_EVICT)))
    else $error("writeback flag does not match eviction status");

  // misses carry no frame or victim
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_rsp.status == STAT_REL_MISS) ||
                   (out_rsp.status == STAT_ALL_PINNED)))
      |-> ((out_rsp.frame_index == '0) && (out_rsp.victim_addr == '0)))
    else $error("miss result carries frame or victim");

  // a commit never overwrites a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.commit)
    else $error("commit while output stalled");

endmodule

// ===== rtl/core/lbp_ctrl.sv =====
`timescale 1ns / 1ps
module lbp_ctrl import lbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = FSM_LOOK;
        end
      end
      FSM_LOOK: begin
        cmd.latch_dec = 1'b1;
        state_nxt     = FSM_UPD;
      end
      FSM_UPD: begin
        // commit and take the next request on the same edge
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          in_stall   = 1'b0;
          if (in_valid) begin
            cmd.load_req = 1'b1;
            state_nxt    = FSM_LOOK;
          end else begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/lbp_datapath.sv =====
`timescale 1ns / 1ps
module lbp_datapath import lbp_pkg::*; #(
  parameter int  FRAMES    = FRAMES_DEF,
  parameter int  ADDR_BITS = ADDR_BITS_DEF,
  localparam int IDX_W     = $clog2(FRAMES)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  req_t     in_req,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  output logic     out_valid,
  input  logic     out_stall,
  output rsp_t     out_rsp
);

  // request register
  req_t                 req_r;
  logic [ADDR_BITS-1:0] addr;

  // frame state
  logic [ADDR_BITS-1:0] tag_r   [FRAMES];
  logic [ADDR_BITS-1:0] tag_nxt [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    valid_nxt;
  logic [PIN_W-1:0]     pin_r   [FRAMES];
  logic [PIN_W-1:0]     pin_nxt [FRAMES];
  // recency age: 0 = most recent, unique among valid frames
  logic [IDX_W-1:0]     age_r   [FRAMES];
  logic [IDX_W-1:0]     age_nxt [FRAMES];

  // lookup results
  logic             hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [FRAMES-1:0] bucket;
  logic [IDX_W-1:0]  best_age;

  // update
  logic             touch_en;
  logic [IDX_W-1:0] touch_idx;
  rsp_t             rsp_nxt;
  rsp_t             out_rsp_r;
  logic             out_valid_r;

  assign addr = ADDR_BITS'(req_r.page_addr);

  // lookup: tag match, first free frame, LRU unpinned frame
  always_comb begin
    hit_found_nxt  = 1'b0;
    hit_idx_nxt    = '0;
    free_found_nxt = 1'b0;
    free_idx_nxt   = '0;
    bucket         = '0;
    vic_found_nxt  = 1'b0;
    best_age       = '0;
    vic_idx_nxt    = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (valid_r[f] && (tag_r[f] == addr)) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = IDX_W'(f);
      end
      if (!valid_r[f]) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = IDX_W'(f);
      end
      if (valid_r[f] && (pin_r[f] == '0)) begin
        bucket[age_r[f]] = 1'b1;
      end
    end
    for (int a = 0; a < FRAMES; a++) begin
      if (bucket[a]) begin
        vic_found_nxt = 1'b1;
        best_age      = IDX_W'(a);
      end
    end
    for (int f = 0; f < FRAMES; f++) begin
      if (valid_r[f] && (pin_r[f] == '0) && (age_r[f] == best_age)) begin
        vic_idx_nxt = IDX_W'(f);
      end
    end
  end

  // update of frame state and result
  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    pin_nxt   = pin_r;
    age_nxt   = age_r;
    rsp_nxt   = '0;
    touch_en  = 1'b0;
    touch_idx = '0;
    if (req_r.opcode == OP_RELEASE) begin
      if (hit_found_r) begin
        if (pin_r[hit_idx_r] != '0) begin
          pin_nxt[hit_idx_r] = pin_r[hit_idx_r] - 1'b1;
        end
        rsp_nxt.status      = STAT_RELEASED;
        rsp_nxt.frame_index = FIDX_W'(hit_idx_r);
      end else begin
        rsp_nxt.status = STAT_REL_MISS;
      end
    end else if (hit_found_r) begin
      if (pin_r[hit_idx_r] != PIN_MAX) begin
        pin_nxt[hit_idx_r] = pin_r[hit_idx_r] + 1'b1;
      end
      touch_en            = 1'b1;
      touch_idx           = hit_idx_r;
      rsp_nxt.status      = STAT_HIT;
      rsp_nxt.frame_index = FIDX_W'(hit_idx_r);
    end else if (free_found_r) begin
      for (int f = 0; f < FRAMES; f++) begin
        if (valid_r[f]) begin
          age_nxt[f] = IDX_W'(age_r[f] + 1'b1);
        end
      end
      valid_nxt[free_idx_r] = 1'b1;
      tag_nxt[free_idx_r]   = addr;
      pin_nxt[free_idx_r]   = PIN_W'(1);
      age_nxt[free_idx_r]   = '0;
      rsp_nxt.status        = STAT_FREE;
      rsp_nxt.frame_index   = FIDX_W'(free_idx_r);
    end else if (vic_found_r) begin
      rsp_nxt.victim_addr     = PAGE_W'(tag_r[vic_idx_r]);
      rsp_nxt.needs_writeback = 1'b1;
      tag_nxt[vic_idx_r]      = addr;
      pin_nxt[vic_idx_r]      = PIN_W'(1);
      touch_en                = 1'b1;
      touch_idx               = vic_idx_r;
      rsp_nxt.status          = STAT_EVICT;
      rsp_nxt.frame_index     = FIDX_W'(vic_idx_r);
    end else begin
      rsp_nxt.status = STAT_ALL_PINNED;
    end
    // move to front: younger frames age by one
    if (touch_en) begin
      for (int f = 0; f < FRAMES; f++) begin
        if (valid_r[f] && (age_r[f] < age_r[touch_idx])) begin
          age_nxt[f] = IDX_W'(age_r[f] + 1'b1);
        end
      end
      age_nxt[touch_idx] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
    if (cmd.latch_dec) begin
      hit_found_r  <= hit_found_nxt;
      hit_idx_r    <= hit_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      vic_found_r  <= vic_found_nxt;
      vic_idx_r    <= vic_idx_nxt;
    end
    if (cmd.commit) begin
      tag_r     <= tag_nxt;
      age_r     <= age_nxt;
      out_rsp_r <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        pin_r[f] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        valid_r     <= valid_nxt;
        pin_r       <= pin_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_full = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_rsp       = out_rsp_r;

endmodule
